// File: hdl/ptwd_pkg.sv
// Shared types, register map and constants of the private timer and watchdog.
package ptwd_pkg;

  localparam int unsigned COUNT_WIDTH    = 32;
  localparam int unsigned PRESCALE_WIDTH = 8;
  localparam int unsigned PRESCALE_LSB   = 8;
  localparam int unsigned CTL_WIDTH      = PRESCALE_LSB + PRESCALE_WIDTH;

  // Commands carried by an input item.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // Register offsets inside one counter unit.
  localparam logic [1:0] SUB_LOAD   = 2'd0;
  localparam logic [1:0] SUB_COUNT  = 2'd1;
  localparam logic [1:0] SUB_CTL    = 2'd2;
  localparam logic [1:0] SUB_STATUS = 2'd3;

  // Word index groups and the standalone watchdog registers.
  localparam logic [1:0] GRP_TIMER   = 2'b00;
  localparam logic [1:0] GRP_DOG     = 2'b10;
  localparam logic [3:0] REG_DOG_RST = 4'd12;
  localparam logic [3:0] REG_DOG_DIS = 4'd13;

  // Control register bits.
  localparam int unsigned CTL_ENABLE   = 0;
  localparam int unsigned CTL_RELOAD   = 1;
  localparam int unsigned CTL_IRQ_EN   = 2;
  localparam int unsigned CTL_DOG_MODE = 3;

  localparam logic [CTL_WIDTH-1:0] CTL_BASE_MASK =
      CTL_WIDTH'((1 << CTL_ENABLE) | (1 << CTL_RELOAD) | (1 << CTL_IRQ_EN)
                 | (((1 << PRESCALE_WIDTH) - 1) << PRESCALE_LSB));
  localparam logic [CTL_WIDTH-1:0] CTL_MODE_MASK = CTL_WIDTH'(1 << CTL_DOG_MODE);

  localparam logic [31:0] DIS_KEY1 = 32'h1234_5678;
  localparam logic [31:0] DIS_KEY2 = 32'h8765_4321;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  reg_index;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        timer_irq;
    logic        watchdog_irq;
    logic        system_reset;
  } out_item_t;

  // Request from the top level to one counter unit for the current item.
  typedef struct packed {
    logic        tick;
    logic        wr;
    logic [1:0]  sub;
    logic [31:0] data;
    logic        mode_clr;
  } unit_req_t;

  // Status of one counter unit.
  typedef struct packed {
    logic [31:0] rd_data;
    logic        irq;
    logic        dog_hit;
  } unit_stat_t;

endpackage

// File: hdl/ptwd_unit.sv
// One prescaled countdown counter with its load, control and event registers.
module ptwd_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               is_dog_i,
  input  ptwd_pkg::unit_req_t req_i,
  output ptwd_pkg::unit_stat_t stat_o
);
  import ptwd_pkg::*;

  logic [COUNT_WIDTH-1:0]    reload_q, reload_d;
  logic [COUNT_WIDTH-1:0]    count_q, count_d;
  logic [CTL_WIDTH-1:0]      ctl_q, ctl_d;
  logic                      event_q, event_d;
  logic [PRESCALE_WIDTH-1:0] presc_q, presc_d;
  logic                      hit;
  logic [PRESCALE_WIDTH-1:0] presc_max;
  logic                      dog_mode;

  assign presc_max = ctl_q[PRESCALE_LSB +: PRESCALE_WIDTH];
  assign dog_mode  = is_dog_i & ctl_q[CTL_DOG_MODE];

  always_comb begin
    reload_d = reload_q;
    count_d  = count_q;
    ctl_d    = ctl_q;
    event_d  = event_q;
    presc_d  = presc_q;
    hit      = 1'b0;
    if (req_i.tick && ctl_q[CTL_ENABLE]) begin
      if (presc_q != presc_max) begin
        presc_d = presc_q + PRESCALE_WIDTH'(1);
      end else begin
        presc_d = '0;
        if (count_q == '0) begin
          // A counter parked at zero reloads on its next count only in timer mode with auto-reload on.
          if (!dog_mode && ctl_q[CTL_RELOAD]) begin
            count_d = reload_q;
            if (reload_q == '0) begin
              event_d = 1'b1;
            end
          end
        end else begin
          count_d = count_q - COUNT_WIDTH'(1);
          if (count_q == COUNT_WIDTH'(1)) begin
            if (dog_mode) begin
              hit = 1'b1;
            end else begin
              event_d = 1'b1;
            end
          end
        end
      end
    end
    if (req_i.wr) begin
      unique case (req_i.sub)
        SUB_LOAD: begin
          reload_d = COUNT_WIDTH'(req_i.data);
          count_d  = COUNT_WIDTH'(req_i.data);
        end
        SUB_COUNT: begin
          count_d = COUNT_WIDTH'(req_i.data);
        end
        SUB_CTL: begin
          // The mode bit can be set by a write but never cleared by one.
          ctl_d = (CTL_WIDTH'(req_i.data) & CTL_BASE_MASK)
                | ({CTL_WIDTH{is_dog_i}} & CTL_MODE_MASK
                   & (CTL_WIDTH'(req_i.data) | ctl_q));
          presc_d = '0;
        end
        SUB_STATUS: begin
          if (req_i.data[0]) begin
            event_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (req_i.mode_clr) begin
      ctl_d[CTL_DOG_MODE] = 1'b0;
    end
  end

  always_comb begin
    unique case (req_i.sub)
      SUB_LOAD:   stat_o.rd_data = 32'(reload_q);
      SUB_COUNT:  stat_o.rd_data = 32'(count_q);
      SUB_CTL:    stat_o.rd_data = 32'(ctl_q);
      SUB_STATUS: stat_o.rd_data = {31'd0, event_q};
      default:    stat_o.rd_data = '0;
    endcase
    stat_o.irq     = event_d & ctl_d[CTL_IRQ_EN] & ~ctl_d[CTL_DOG_MODE];
    stat_o.dog_hit = hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= '0;
      count_q  <= '0;
      ctl_q    <= '0;
      event_q  <= 1'b0;
      presc_q  <= '0;
    end else begin
      reload_q <= reload_d;
      count_q  <= count_d;
      ctl_q    <= ctl_d;
      event_q  <= event_d;
      presc_q  <= presc_d;
    end
  end

endmodule

// File: hdl/private_timer_and_watchdog.sv
// Top level of the per-core private timer and watchdog.
//
//   Channel   Direction  Handshake                 Payload
//   in        into       in_valid_i / in_ready_o   in_item_i  (command, index, data)
//   out       out of     out_valid_o / out_ready_i out_item_o (read data, irq, reset)
//
// One item is accepted per cycle when the result register drains at the same rate.
// An accepted item waits in the input register, where it updates the counters and
// loads the result register; its result is valid once the result register is loaded
// and is held there until it is taken.
// Reset clears every register of both counters, the reset flag and the disable
// sequence. When the result register is stalled, the input register holds one
// item and input ready drops until the result is taken.
module private_timer_and_watchdog (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ptwd_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ptwd_pkg::out_item_t out_item_o
);
  import ptwd_pkg::*;

  logic       in_vld_q;
  in_item_t   in_q;
  logic       out_vld_q;
  out_item_t  out_q, out_d;
  logic       advance;

  logic       is_wr, is_rd, is_tick;
  logic       hit_timer, hit_dog;
  unit_req_t  t_req, d_req;
  unit_stat_t t_stat, d_stat;

  logic       rst_flag_q, rst_flag_d;
  logic       armed_q, armed_d;
  logic       mode_clr;

  // The item in the input register is processed whenever the result register
  // is empty or being emptied in the same cycle.
  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;

  assign is_tick   = advance & (in_q.command == CMD_TICK);
  assign is_wr     = advance & (in_q.command == CMD_WRITE);
  assign is_rd     = in_q.command == CMD_READ;
  assign hit_timer = in_q.reg_index[3:2] == GRP_TIMER;
  assign hit_dog   = in_q.reg_index[3:2] == GRP_DOG;

  // Disable sequence: the first key arms it, the second key on the next write to
  // that register drops watchdog mode; any other write to that register except the
  // first key disarms it. Accesses to other registers leave the arming alone.
  always_comb begin
    armed_d  = armed_q;
    mode_clr = 1'b0;
    if (is_wr && in_q.reg_index == REG_DOG_DIS) begin
      if (armed_q && in_q.write_data == DIS_KEY2) begin
        mode_clr = 1'b1;
        armed_d  = 1'b0;
      end else begin
        armed_d = in_q.write_data == DIS_KEY1;
      end
    end
  end

  always_comb begin
    t_req.tick     = is_tick;
    t_req.wr       = is_wr & hit_timer;
    t_req.sub      = in_q.reg_index[1:0];
    t_req.data     = in_q.write_data;
    t_req.mode_clr = 1'b0;
    d_req.tick     = is_tick;
    d_req.wr       = is_wr & hit_dog;
    d_req.sub      = in_q.reg_index[1:0];
    d_req.data     = in_q.write_data;
    d_req.mode_clr = mode_clr;
  end

  ptwd_unit u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_dog_i (1'b0),
    .req_i    (t_req),
    .stat_o   (t_stat)
  );

  ptwd_unit u_dog (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_dog_i (1'b1),
    .req_i    (d_req),
    .stat_o   (d_stat)
  );

  // The reset flag is set when the watchdog runs out in watchdog mode and is
  // held until software clears it through the reset status register.
  always_comb begin
    rst_flag_d = rst_flag_q;
    if (d_stat.dog_hit) begin
      rst_flag_d = 1'b1;
    end else if (is_wr && in_q.reg_index == REG_DOG_RST && in_q.write_data[0]) begin
      rst_flag_d = 1'b0;
    end
  end

  // Reads return the state as it stood before this item; the interrupt and
  // reset lines show the state after it. Unused indexes read as zero.
  always_comb begin
    out_d.read_data = '0;
    if (is_rd) begin
      priority if (hit_timer) begin
        out_d.read_data = t_stat.rd_data;
      end else if (hit_dog) begin
        out_d.read_data = d_stat.rd_data;
      end else if (in_q.reg_index == REG_DOG_RST) begin
        out_d.read_data = {31'd0, rst_flag_q};
      end else begin
        out_d.read_data = '0;
      end
    end
    out_d.timer_irq    = t_stat.irq;
    out_d.watchdog_irq = d_stat.irq;
    out_d.system_reset = rst_flag_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      rst_flag_q <= 1'b0;
      armed_q    <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (advance) begin
        out_vld_q  <= 1'b1;
        rst_flag_q <= rst_flag_d;
        armed_q    <= armed_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// File: hdl/ptwd_checker.sv
// Port-level checks for the private timer and watchdog, bound to the top level.
module ptwd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ptwd_pkg::out_item_t out_item_o
);

  // Input back-pressure only ever comes from a stalled result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while no result is pending");

  // A result is only withdrawn after it was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result dropped without being taken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("output item changed while stalled");

endmodule

bind private_timer_and_watchdog ptwd_checker u_ptwd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// File: dv/tb.sv
// Self-checking testbench for the private timer and watchdog: directed and random accesses.
module tb;
  import ptwd_pkg::*;

  // The fourth command code is unused by the block and must act as a no-op.
  localparam logic [1:0] CMD_NONE = 2'd3;

  // Word indexes of the register map, built from the package's group and offset codes.
  localparam logic [3:0] IDX_T_LOAD   = {GRP_TIMER, SUB_LOAD};
  localparam logic [3:0] IDX_T_COUNT  = {GRP_TIMER, SUB_COUNT};
  localparam logic [3:0] IDX_T_CTL    = {GRP_TIMER, SUB_CTL};
  localparam logic [3:0] IDX_T_STATUS = {GRP_TIMER, SUB_STATUS};
  localparam logic [3:0] IDX_D_LOAD   = {GRP_DOG, SUB_LOAD};
  localparam logic [3:0] IDX_D_COUNT  = {GRP_DOG, SUB_COUNT};
  localparam logic [3:0] IDX_D_CTL    = {GRP_DOG, SUB_CTL};
  localparam logic [3:0] IDX_D_STATUS = {GRP_DOG, SUB_STATUS};
  localparam logic [3:0] IDX_UNUSED_LO = 4'd5;
  localparam logic [3:0] IDX_UNUSED_HI = 4'd14;

  localparam int unsigned RANDOM_ITEMS   = 525;
  localparam int unsigned HOLD_AT        = 200;  // result count at which the sink backs off
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // Mirror of one counter unit: reload, count, control, event flag and prescale counter.
  typedef struct {
    bit [COUNT_WIDTH-1:0]    reload;
    bit [COUNT_WIDTH-1:0]    count;
    bit [CTL_WIDTH-1:0]      ctl;
    bit                      evt;
    bit [PRESCALE_WIDTH-1:0] pre;
  } unit_state_t;

  // Shadow copy of the register file. Every accepted access is applied here and the
  // status it should produce is queued; each result from the block is matched in order.
  class ptwd_shadow;
    unit_state_t tmr;
    unit_state_t dog;
    bit          reset_flag;
    bit          unlock_armed;
    out_item_t   status_due_q[$];
    int unsigned mismatches;

    function new();
      tmr = '{default: '0};
      dog = '{default: '0};
      reset_flag = 1'b0;
      unlock_armed = 1'b0;
      mismatches = 0;
    endfunction

    function void count_tick(inout unit_state_t u, input bit is_dog);
      bit dog_mode;
      dog_mode = is_dog && u.ctl[CTL_DOG_MODE];
      if (!u.ctl[CTL_ENABLE]) return;
      if (u.pre != u.ctl[PRESCALE_LSB +: PRESCALE_WIDTH]) begin
        u.pre = u.pre + 1'b1;
        return;
      end
      u.pre = '0;
      if (u.count == '0) begin
        // A counter parked at zero reloads only in timer mode with auto-reload on.
        if (!dog_mode && u.ctl[CTL_RELOAD]) begin
          u.count = u.reload;
          if (u.count == '0) u.evt = 1'b1;
        end
        return;
      end
      u.count = u.count - 1'b1;
      if (u.count == '0) begin
        if (dog_mode) reset_flag = 1'b1;
        else u.evt = 1'b1;
      end
    endfunction

    function void store_unit(inout unit_state_t u, input logic [1:0] sub,
                             input logic [31:0] data, input bit is_dog);
      case (sub)
        SUB_LOAD: begin
          u.reload = data;
          u.count  = data;
        end
        SUB_COUNT: u.count = data;
        SUB_CTL: begin
          // The watchdog mode bit is sticky: a write can set it but never clear it.
          if (is_dog) u.ctl = (data[CTL_WIDTH-1:0] & (CTL_BASE_MASK | CTL_MODE_MASK))
                              | (u.ctl & CTL_MODE_MASK);
          else u.ctl = data[CTL_WIDTH-1:0] & CTL_BASE_MASK;
          u.pre = '0;
        end
        default: if (data[0]) u.evt = 1'b0;
      endcase
    endfunction

    function logic [31:0] fetch_unit(unit_state_t u, logic [1:0] sub);
      case (sub)
        SUB_LOAD:  return u.reload;
        SUB_COUNT: return u.count;
        SUB_CTL:   return 32'(u.ctl);
        default:   return 32'(u.evt);
      endcase
    endfunction

    function void apply_access(in_item_t it);
      logic [31:0] rd;
      out_item_t   want;
      rd = '0;
      case (it.command)
        CMD_TICK: begin
          count_tick(tmr, 1'b0);
          count_tick(dog, 1'b1);
        end
        CMD_WRITE: begin
          if (it.reg_index[3:2] == GRP_TIMER) begin
            store_unit(tmr, it.reg_index[1:0], it.write_data, 1'b0);
          end else if (it.reg_index[3:2] == GRP_DOG) begin
            store_unit(dog, it.reg_index[1:0], it.write_data, 1'b1);
          end else if (it.reg_index == REG_DOG_RST) begin
            if (it.write_data[0]) reset_flag = 1'b0;
          end else if (it.reg_index == REG_DOG_DIS) begin
            if (unlock_armed && it.write_data == DIS_KEY2) begin
              dog.ctl[CTL_DOG_MODE] = 1'b0;
              unlock_armed = 1'b0;
            end else begin
              unlock_armed = (it.write_data == DIS_KEY1);
            end
          end
        end
        CMD_READ: begin
          if (it.reg_index[3:2] == GRP_TIMER) rd = fetch_unit(tmr, it.reg_index[1:0]);
          else if (it.reg_index[3:2] == GRP_DOG) rd = fetch_unit(dog, it.reg_index[1:0]);
          else if (it.reg_index == REG_DOG_RST) rd = 32'(reset_flag);
        end
        default: ;
      endcase
      want.read_data    = rd;
      want.timer_irq    = tmr.evt && tmr.ctl[CTL_IRQ_EN];
      want.watchdog_irq = dog.evt && dog.ctl[CTL_IRQ_EN] && !dog.ctl[CTL_DOG_MODE];
      want.system_reset = reset_flag;
      status_due_q.push_back(want);
    endfunction

    function void compare_status(out_item_t got);
      out_item_t want;
      if (status_due_q.size() == 0) begin
        $error("result item with none expected: %h", got);
        mismatches++;
        return;
      end
      want = status_due_q.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %h, got %h", want.read_data, got.read_data);
        mismatches++;
      end
      if (got.timer_irq !== want.timer_irq) begin
        $error("timer_irq: expected %b, got %b", want.timer_irq, got.timer_irq);
        mismatches++;
      end
      if (got.watchdog_irq !== want.watchdog_irq) begin
        $error("watchdog_irq: expected %b, got %b", want.watchdog_irq, got.watchdog_irq);
        mismatches++;
      end
      if (got.system_reset !== want.system_reset) begin
        $error("system_reset: expected %b, got %b", want.system_reset, got.system_reset);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return status_due_q.size();
    endfunction
  endclass

  bit        clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_item_o;

  ptwd_shadow shadow = new();

  private_timer_and_watchdog dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o (out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic in_item_t access(logic [1:0] cmd, logic [3:0] idx, logic [31:0] data);
    in_item_t it;
    it.command    = cmd;
    it.reg_index  = idx;
    it.write_data = data;
    return it;
  endfunction

  // Idle cycles before the next item. Every third block of 40 items runs back to back so
  // that both full-rate streaming and gaps at every phase get exercised.
  function automatic int unsigned pace(int unsigned seq);
    return ((seq / 40) % 3 == 1) ? 0 : $urandom_range(0, 12);
  endfunction

  // Random access shaped to reach deep states: half of them ticks against small counts and
  // small prescalers, so that counters really hit zero, reload and raise their flags.
  // A minority of writes carries fully random data so that every data bit toggles.
  function automatic in_item_t random_access();
    in_item_t    it;
    int unsigned pick;
    logic [3:0]  slot;
    pick = $urandom_range(0, 99);
    it.command = (pick < 50) ? CMD_TICK : (pick < 75) ? CMD_WRITE :
                 (pick < 96) ? CMD_READ : CMD_NONE;
    it.write_data = $urandom();
    if ($urandom_range(0, 6) == 0) begin
      it.reg_index = 4'($urandom_range(0, 15));
    end else begin
      slot = 4'($urandom_range(0, 9));
      it.reg_index = (slot < 4) ? {GRP_TIMER, slot[1:0]} :
                     (slot < 8) ? {GRP_DOG, slot[1:0]} :
                     (slot == 8) ? REG_DOG_RST : REG_DOG_DIS;
    end
    if (it.command == CMD_WRITE) begin
      case (it.reg_index)
        IDX_T_LOAD, IDX_T_COUNT, IDX_D_LOAD, IDX_D_COUNT: begin
          if ($urandom_range(0, 4) != 0) it.write_data = $urandom_range(0, 12);
        end
        IDX_T_CTL, IDX_D_CTL: begin
          if ($urandom_range(0, 6) != 0) begin
            it.write_data[PRESCALE_LSB +: PRESCALE_WIDTH] = PRESCALE_WIDTH'($urandom_range(0, 2));
            // Keep watchdog mode rare so the interrupt path of the watchdog gets time too.
            if ($urandom_range(0, 3) != 0) it.write_data[CTL_DOG_MODE] = 1'b0;
            if ($urandom_range(0, 3) != 0) it.write_data[CTL_ENABLE] = 1'b1;
          end
        end
        REG_DOG_DIS: begin
          pick = $urandom_range(0, 4);
          if (pick < 2) it.write_data = DIS_KEY1;
          else if (pick < 4) it.write_data = DIS_KEY2;
        end
        default: ;
      endcase
    end
    return it;
  endfunction

  // Offers one item after a random gap and waits for the handshake. Valid is lowered
  // only when a gap follows, so back-to-back items never see valid dropped and raised
  // in the same time step.
  task automatic offer_access(input in_item_t it, input int unsigned seq);
    int unsigned gap;
    gap = pace(seq);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.apply_access(it);
  endtask

  initial begin : stimulus
    in_item_t    plan_q[$];
    int unsigned seq;

    // Directed opening: reset values, a timer expiring with interrupt, auto-reload,
    // a zero reload re-raising the event, the widest control write, the watchdog
    // raising reset in watchdog mode, the disable sequence with an access in between,
    // the watchdog interrupt in timer mode, unused indexes and the unused command.
    plan_q.push_back(access(CMD_READ,  IDX_T_COUNT,  32'h0));
    plan_q.push_back(access(CMD_WRITE, IDX_T_LOAD,   32'hFFFF_FFFF));
    plan_q.push_back(access(CMD_WRITE, IDX_T_COUNT,  32'h1));
    plan_q.push_back(access(CMD_WRITE, IDX_T_CTL,    32'h0000_0007));
    plan_q.push_back(access(CMD_TICK,  IDX_T_LOAD,   32'h0));
    plan_q.push_back(access(CMD_READ,  IDX_T_STATUS, 32'h0));
    plan_q.push_back(access(CMD_TICK,  IDX_T_LOAD,   32'h0));
    plan_q.push_back(access(CMD_WRITE, IDX_T_STATUS, 32'h1));
    plan_q.push_back(access(CMD_WRITE, IDX_T_LOAD,   32'h0));
    plan_q.push_back(access(CMD_TICK,  IDX_T_LOAD,   32'h0));
    plan_q.push_back(access(CMD_WRITE, IDX_T_CTL,    32'hFFFF_FFFF));
    plan_q.push_back(access(CMD_READ,  IDX_T_CTL,    32'h0));
    plan_q.push_back(access(CMD_WRITE, IDX_D_CTL,    32'h0000_0109));
    plan_q.push_back(access(CMD_WRITE, IDX_D_COUNT,  32'h1));
    plan_q.push_back(access(CMD_TICK,  IDX_T_LOAD,   32'h0));
    plan_q.push_back(access(CMD_TICK,  IDX_T_LOAD,   32'h0));
    plan_q.push_back(access(CMD_READ,  REG_DOG_RST,  32'h0));
    plan_q.push_back(access(CMD_WRITE, REG_DOG_RST,  32'h1));
    plan_q.push_back(access(CMD_WRITE, REG_DOG_DIS,  DIS_KEY1));
    plan_q.push_back(access(CMD_READ,  IDX_D_LOAD,   32'h0));
    plan_q.push_back(access(CMD_WRITE, REG_DOG_DIS,  DIS_KEY2));
    plan_q.push_back(access(CMD_WRITE, IDX_D_CTL,    32'h0000_0007));
    plan_q.push_back(access(CMD_WRITE, IDX_D_COUNT,  32'h1));
    plan_q.push_back(access(CMD_TICK,  IDX_T_LOAD,   32'h0));
    plan_q.push_back(access(CMD_READ,  IDX_D_STATUS, 32'h0));
    plan_q.push_back(access(CMD_WRITE, IDX_UNUSED_LO, 32'hFFFF_FFFF));
    plan_q.push_back(access(CMD_READ,  IDX_UNUSED_HI, 32'h0));
    plan_q.push_back(access(CMD_NONE,  REG_DOG_DIS,  32'hFFFF_FFFF));

    // Reset is held low at the start and then released once for the whole run.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    seq = 0;
    foreach (plan_q[k]) begin
      offer_access(plan_q[k], seq);
      seq++;
    end
    repeat (RANDOM_ITEMS) begin
      offer_access(random_access(), seq);
      seq++;
    end
    in_valid <= 1'b0;

    // Let every outstanding result arrive, then watch a little longer for strays.
    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (shadow.mismatches == 0 && shadow.pending() == 0) begin
      $display("PASS private_timer_and_watchdog");
    end else begin
      $display("FAIL private_timer_and_watchdog");
    end
    $finish;
  end

  // Result sink: random stalls per item, plus one long back-off that fills the block
  // and forces the input side to stall while the source keeps offering items.
  initial begin : result_sink
    int unsigned taken;
    int unsigned hold;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = (taken == HOLD_AT) ? HOLD_CYCLES : pace(taken);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      shadow.compare_status(out_item_o);
      taken++;
    end
  end

  // Hang detection: any accepted item on either side restarts the count.
  initial begin : stall_guard
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL private_timer_and_watchdog");
    $finish;
  end

endmodule

// File: private_timer_and_watchdog.f
hdl/ptwd_pkg.sv
hdl/ptwd_unit.sv
hdl/private_timer_and_watchdog.sv
hdl/ptwd_checker.sv
dv/tb.sv
